// ----- design/acsc_pkg.sv -----
`timescale 1ns / 1ps

package acsc_pkg;

  // fixed field widths of the transaction ports
  localparam int KIND_W    = 5;
  localparam int OPERAND_W = 12;
  localparam int VALUE_W   = 16;
  localparam int ACC_OUT_W = 16;
  localparam int SP_OUT_W  = 12;
  localparam int PC_OUT_W  = 12;

  // largest stack adjust that INSP and DESP honor
  localparam int ADJ_LIMIT = 255;

  // operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 5'd0,
    KIND_LODD = 5'd1,
    KIND_STOD = 5'd2,
    KIND_ADDD = 5'd3,
    KIND_SUBD = 5'd4,
    KIND_JPOS = 5'd5,
    KIND_JZER = 5'd6,
    KIND_JUMP = 5'd7,
    KIND_LOCO = 5'd8,
    KIND_LODL = 5'd9,
    KIND_STOL = 5'd10,
    KIND_ADDL = 5'd11,
    KIND_SUBL = 5'd12,
    KIND_JNEG = 5'd13,
    KIND_JNZE = 5'd14,
    KIND_CALL = 5'd15,
    KIND_PSHI = 5'd16,
    KIND_POPI = 5'd17,
    KIND_PUSH = 5'd18,
    KIND_POP  = 5'd19,
    KIND_RETN = 5'd20,
    KIND_SWAP = 5'd21,
    KIND_INSP = 5'd22,
    KIND_DESP = 5'd23,
    KIND_STOP = 5'd24
  } kind_t;

endpackage

// ----- design/acsc_mem.sv -----
`timescale 1ns / 1ps

module acsc_mem
  import acsc_pkg::*;
#(
  parameter int ADDR_BITS = 12,
  parameter int WORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] q_r;
  logic                 byp_hit_r;
  logic [WORD_BITS-1:0] byp_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // same-cycle write to the read address: take the new word instead
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_hit_r  <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : q_r;

endmodule

// ----- design/acsc_alu.sv -----
`timescale 1ns / 1ps

module acsc_alu
  import acsc_pkg::*;
#(
  parameter int ADDR_BITS = 12,
  parameter int WORD_BITS = 16
) (
  input  kind_t                kind,
  input  logic [ADDR_BITS-1:0] opd,
  input  logic [WORD_BITS-1:0] ld_word,
  input  logic [WORD_BITS-1:0] rd_word,
  input  logic [WORD_BITS-1:0] acc,
  input  logic [ADDR_BITS-1:0] sp,
  input  logic [ADDR_BITS-1:0] pc,
  input  logic                 halt,
  output logic [WORD_BITS-1:0] acc_new,
  output logic [ADDR_BITS-1:0] sp_new,
  output logic [ADDR_BITS-1:0] pc_new,
  output logic                 halt_new,
  output logic                 we,
  output logic [ADDR_BITS-1:0] waddr,
  output logic [WORD_BITS-1:0] wdata
);

  logic [ADDR_BITS-1:0] pc_inc;
  logic [ADDR_BITS-1:0] sp_inc;
  logic [ADDR_BITS-1:0] sp_dec;
  logic [ADDR_BITS-1:0] loc;
  logic                 acc_neg;
  logic                 acc_zero;
  logic                 adj_ok;
  logic                 run;

  // address arithmetic, all wrapping at the address width
  assign pc_inc   = pc + ADDR_BITS'(1);
  assign sp_inc   = sp + ADDR_BITS'(1);
  assign sp_dec   = sp - ADDR_BITS'(1);
  assign loc      = sp + opd;
  assign acc_neg  = acc[WORD_BITS-1];
  assign acc_zero = (acc == '0);
  assign adj_ok   = (opd <= ADDR_BITS'(ADJ_LIMIT));
  assign run      = !halt && (kind inside {[KIND_LODD:KIND_STOP]});

  // instruction execute and memory write request
  always_comb begin
    acc_new  = acc;
    sp_new   = sp;
    pc_new   = pc;
    halt_new = halt;
    we       = 1'b0;
    waddr    = opd;
    wdata    = acc;
    case (kind)
      KIND_LOAD: begin
        we    = 1'b1;
        wdata = ld_word;
      end
      default: begin
        if (run) begin
          pc_new = pc_inc;
          case (kind)
            KIND_LODD: acc_new = rd_word;
            KIND_STOD: we = 1'b1;
            KIND_ADDD: acc_new = acc + rd_word;
            KIND_SUBD: acc_new = acc - rd_word;
            KIND_JPOS: if (!acc_neg) pc_new = opd;
            KIND_JZER: if (acc_zero) pc_new = opd;
            KIND_JUMP: pc_new = opd;
            KIND_LOCO: acc_new = WORD_BITS'(opd);
            KIND_LODL: acc_new = rd_word;
            KIND_STOL: begin
              we    = 1'b1;
              waddr = loc;
            end
            KIND_ADDL: acc_new = acc + rd_word;
            KIND_SUBL: acc_new = acc - rd_word;
            KIND_JNEG: if (acc_neg) pc_new = opd;
            KIND_JNZE: if (!acc_zero) pc_new = opd;
            KIND_CALL: begin
              sp_new = sp_dec;
              we     = 1'b1;
              waddr  = sp_dec;
              wdata  = WORD_BITS'(pc_inc);
              pc_new = opd;
            end
            KIND_PSHI: begin
              sp_new = sp_dec;
              we     = 1'b1;
              waddr  = sp_dec;
              wdata  = rd_word;
            end
            KIND_POPI: begin
              sp_new = sp_inc;
              we     = 1'b1;
              waddr  = ADDR_BITS'(acc);
              wdata  = rd_word;
            end
            KIND_PUSH: begin
              sp_new = sp_dec;
              we     = 1'b1;
              waddr  = sp_dec;
            end
            KIND_POP: begin
              acc_new = rd_word;
              sp_new  = sp_inc;
            end
            KIND_RETN: begin
              pc_new = ADDR_BITS'(rd_word);
              sp_new = sp_inc;
            end
            KIND_SWAP: begin
              acc_new = WORD_BITS'(sp);
              sp_new  = ADDR_BITS'(acc);
            end
            KIND_INSP: if (adj_ok) sp_new = sp + opd;
            KIND_DESP: if (adj_ok) sp_new = sp - opd;
            KIND_STOP: halt_new = 1'b1;
            default: ;
          endcase
        end
      end
    endcase
  end

endmodule

// ----- design/accumulator_stack_cpu_execute.sv -----
`timescale 1ns / 1ps

// Execute unit for an accumulator/stack instruction set with a local word memory.
// Input channel (in_valid/in_stall): one transaction is either a load word, which
// places in_load_value at address in_operand, or one instruction named by in_kind.
// Result channel (out_valid/out_stall): exactly one transaction per input, giving
// accumulator, stack pointer, program counter and halt flag after that step.
// Timing: an accepted input waits in the execute stage register, then its result
// moves to the result register. The block accepts one transaction per cycle while
// in_stall is low; the memory has one read and one write port, with the read at accept,
// the write-back as execute completes and a bypass for a write to the address read.
// When out_stall holds a result, one more transaction is taken into the execute
// stage and then in_stall rises until the result register drains.
// Reset clears accumulator, stack pointer, program counter, halt flag and both
// valid flags; memory contents are not cleared and must be loaded before use.
module accumulator_stack_cpu_execute
  import acsc_pkg::*;
#(
  parameter int ADDR_BITS = 12,
  parameter int WORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [KIND_W-1:0]           in_kind,
  input  logic [OPERAND_W-1:0]        in_operand,
  input  logic signed [VALUE_W-1:0]   in_load_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ACC_OUT_W-1:0] out_acc_value,
  output logic [SP_OUT_W-1:0]         out_stack_pointer,
  output logic [PC_OUT_W-1:0]         out_program_counter,
  output logic                        out_halted
);

  // architectural state
  logic [WORD_BITS-1:0] acc_r;
  logic [ADDR_BITS-1:0] sp_r;
  logic [ADDR_BITS-1:0] pc_r;
  logic                 halt_r;

  // execute stage
  logic                 s2_valid_r;
  logic                 s2_valid_nxt;
  kind_t                s2_kind_r;
  logic [ADDR_BITS-1:0] s2_opd_r;
  logic [WORD_BITS-1:0] s2_word_r;

  // result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [ACC_OUT_W-1:0] out_acc_r;
  logic [SP_OUT_W-1:0]  out_sp_r;
  logic [PC_OUT_W-1:0]  out_pc_r;
  logic                 out_halt_r;

  logic                 s2_go;
  logic                 in_acc;
  kind_t                in_kind_e;
  logic [ADDR_BITS-1:0] in_opd;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] acc_new;
  logic [ADDR_BITS-1:0] sp_new;
  logic [ADDR_BITS-1:0] pc_new;
  logic                 halt_new;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] acc_fwd;
  logic [ADDR_BITS-1:0] sp_fwd;

  // handshake control
  assign s2_go    = s2_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s2_valid_r && !s2_go;
  assign in_acc   = in_valid && !in_stall;

  assign s2_valid_nxt  = in_acc ? 1'b1 : (s2_go ? 1'b0 : s2_valid_r);
  assign out_valid_nxt = s2_go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // state as seen by the incoming transaction: the executing one commits now
  assign acc_fwd = s2_valid_r ? acc_new : acc_r;
  assign sp_fwd  = s2_valid_r ? sp_new  : sp_r;

  assign in_kind_e = kind_t'(in_kind);
  assign in_opd    = ADDR_BITS'(in_operand);

  // memory read address for the incoming transaction
  always_comb begin
    case (in_kind_e)
      KIND_LODL, KIND_ADDL, KIND_SUBL: rd_addr = sp_fwd + in_opd;
      KIND_PSHI:                       rd_addr = ADDR_BITS'(acc_fwd);
      KIND_POPI, KIND_POP, KIND_RETN:  rd_addr = sp_fwd;
      default:                         rd_addr = in_opd;
    endcase
  end

  acsc_mem #(
    .ADDR_BITS (ADDR_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s2_go && we),
    .wr_addr (waddr),
    .wr_data (wdata)
  );

  acsc_alu #(
    .ADDR_BITS (ADDR_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .kind     (s2_kind_r),
    .opd      (s2_opd_r),
    .ld_word  (s2_word_r),
    .rd_word  (rd_data),
    .acc      (acc_r),
    .sp       (sp_r),
    .pc       (pc_r),
    .halt     (halt_r),
    .acc_new  (acc_new),
    .sp_new   (sp_new),
    .pc_new   (pc_new),
    .halt_new (halt_new),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata)
  );

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      sp_r        <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_go) begin
        acc_r  <= acc_new;
        sp_r   <= sp_new;
        pc_r   <= pc_new;
        halt_r <= halt_new;
      end
    end
  end

  // execute stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_kind_r <= in_kind_e;
      s2_opd_r  <= in_opd;
      s2_word_r <= WORD_BITS'(in_load_value);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_acc_r  <= ACC_OUT_W'(acc_new);
      out_sp_r   <= SP_OUT_W'(sp_new);
      out_pc_r   <= PC_OUT_W'(pc_new);
      out_halt_r <= halt_new;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_acc_value       = out_acc_r;
  assign out_stack_pointer   = out_sp_r;
  assign out_program_counter = out_pc_r;
  assign out_halted          = out_halt_r;

endmodule
